// ===== hdl/assert_macros.svh =====
// Assertion macros for the RTL of the LRU order list.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that the consequent holds in the same cycle as the antecedent.
`define AST_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that the consequent holds in the cycle after the antecedent.
`define AST_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== hdl/lol_pkg.sv =====
// Package with sizes, opcodes and sequencer states of the LRU order list.
`default_nettype none
package lol_pkg;

  localparam int ENTRIES = 16;
  localparam int IDX_W   = $clog2(ENTRIES);
  localparam int CNT_W   = $clog2(ENTRIES + 1);
  localparam int SLOT_W  = 4;

  typedef enum logic [1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_TOUCH = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UNLINK,
    S_APPEND,
    S_REPORT
  } state_t;

endpackage
`default_nettype wire

// ===== hdl/lru_order_list_top.sv =====
// Top level of the LRU order list: linked-list sequencer with link memories.
//
// A request is taken when start is high and busy is low; busy then stays high
// until the result has been shown. The result appears with done high for
// exactly one cycle and cannot be held off, so it must be captured on that
// cycle. A rejected request or a touch of the tail goes from idle straight
// to report, a push passes through append, a pop through unlink, and a
// touch of any other slot through unlink and then append: the next-link and
// previous-link memories each have one write port, so the unlink and append
// rewrites of a touch go in separate states; link reads are registered.
// In-list marks are flip-flops cleared at reset; no clearing pass is needed.
`default_nettype none
`include "assert_macros.svh"
module lru_order_list_top (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [1:0]                opcode,
  input  wire logic [lol_pkg::SLOT_W-1:0] slot,
  output logic                           busy,
  output logic                           done,
  output logic                           status,
  output logic [lol_pkg::SLOT_W-1:0]     head_slot,
  output logic                           list_empty,
  output logic [lol_pkg::CNT_W-1:0]      entry_count
);

  lol_pkg::state_t state, state_next;

  logic [lol_pkg::IDX_W-1:0]   head, head_next;
  logic [lol_pkg::IDX_W-1:0]   tail, tail_next;
  logic [lol_pkg::CNT_W-1:0]   total, total_next;
  logic [lol_pkg::ENTRIES-1:0] mark, mark_next;

  logic [1:0]                op_q, op_next;
  logic [lol_pkg::IDX_W-1:0] slot_q, slot_next;
  logic                      rejected, rejected_next;

  logic [lol_pkg::IDX_W-1:0] next_mem [lol_pkg::ENTRIES];
  logic [lol_pkg::IDX_W-1:0] prev_mem [lol_pkg::ENTRIES];
  logic [lol_pkg::IDX_W-1:0] nl_rdata, pl_rdata;
  logic [lol_pkg::IDX_W-1:0] nl_raddr;
  logic                      nl_we, pl_we;
  logic [lol_pkg::IDX_W-1:0] nl_waddr, nl_wdata, pl_waddr, pl_wdata;

  logic                      in_range;
  logic [lol_pkg::IDX_W-1:0] slot_idx;
  logic                      reject_in;

  assign in_range = 32'(slot) < lol_pkg::ENTRIES;
  assign slot_idx = in_range ? lol_pkg::IDX_W'(slot) : '0;
  assign nl_raddr = (opcode == lol_pkg::OP_POP) ? head : slot_idx;

  always_comb begin
    case (opcode)
      lol_pkg::OP_PUSH:  reject_in = !in_range || mark[slot_idx];
      lol_pkg::OP_POP:   reject_in = (total == '0);
      lol_pkg::OP_TOUCH: reject_in = (total == '0) || !in_range || !mark[slot_idx];
      default:           reject_in = 1'b1;
    endcase
  end

  // Link memories: one write port, one registered read port each.
  always_ff @(posedge clk) begin
    if (nl_we) begin
      next_mem[nl_waddr] <= nl_wdata;
    end
    if (pl_we) begin
      prev_mem[pl_waddr] <= pl_wdata;
    end
    nl_rdata <= next_mem[nl_raddr];
    pl_rdata <= prev_mem[slot_idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= lol_pkg::S_IDLE;
      head  <= '0;
      tail  <= '0;
      total <= '0;
      mark  <= '0;
    end else begin
      state <= state_next;
      head  <= head_next;
      tail  <= tail_next;
      total <= total_next;
      mark  <= mark_next;
    end
  end

  always_ff @(posedge clk) begin
    op_q     <= op_next;
    slot_q   <= slot_next;
    rejected <= rejected_next;
  end

  always_comb begin
    state_next    = state;
    head_next     = head;
    tail_next     = tail;
    total_next    = total;
    mark_next     = mark;
    op_next       = op_q;
    slot_next     = slot_q;
    rejected_next = rejected;
    nl_we         = 1'b0;
    nl_waddr      = tail;
    nl_wdata      = slot_q;
    pl_we         = 1'b0;
    pl_waddr      = slot_q;
    pl_wdata      = tail;
    unique case (state)
      lol_pkg::S_IDLE: begin
        if (start) begin
          op_next       = opcode;
          slot_next     = slot_idx;
          rejected_next = reject_in;
          if (reject_in) begin
            state_next = lol_pkg::S_REPORT;
          end else begin
            case (opcode)
              lol_pkg::OP_PUSH:  state_next = lol_pkg::S_APPEND;
              lol_pkg::OP_POP:   state_next = lol_pkg::S_UNLINK;
              lol_pkg::OP_TOUCH: state_next = (slot_idx == tail) ? lol_pkg::S_REPORT
                                                                  : lol_pkg::S_UNLINK;
              default:           state_next = lol_pkg::S_REPORT;
            endcase
          end
        end
      end
      lol_pkg::S_UNLINK: begin
        if (op_q == lol_pkg::OP_POP) begin
          mark_next[head] = 1'b0;
          total_next      = lol_pkg::CNT_W'(total - 1'b1);
          if (total == lol_pkg::CNT_W'(1)) begin
            head_next = '0;
            tail_next = '0;
          end else begin
            head_next = nl_rdata;
          end
          state_next = lol_pkg::S_REPORT;
        end else begin
          if (slot_q == head) begin
            head_next = nl_rdata;
          end else begin
            // splice neighbors around the touched slot
            nl_we    = 1'b1;
            nl_waddr = pl_rdata;
            nl_wdata = nl_rdata;
            pl_we    = 1'b1;
            pl_waddr = nl_rdata;
            pl_wdata = pl_rdata;
          end
          state_next = lol_pkg::S_APPEND;
        end
      end
      lol_pkg::S_APPEND: begin
        if (op_q == lol_pkg::OP_PUSH) begin
          mark_next[slot_q] = 1'b1;
          total_next        = lol_pkg::CNT_W'(total + 1'b1);
        end
        if (total == '0) begin
          head_next = slot_q;
        end else begin
          nl_we = 1'b1;
          pl_we = 1'b1;
        end
        tail_next  = slot_q;
        state_next = lol_pkg::S_REPORT;
      end
      lol_pkg::S_REPORT: begin
        state_next = lol_pkg::S_IDLE;
      end
      default: begin
        state_next = lol_pkg::S_IDLE;
      end
    endcase
  end

  assign busy        = (state != lol_pkg::S_IDLE);
  assign done        = (state == lol_pkg::S_REPORT);
  assign status      = rejected;
  assign list_empty  = (total == '0);
  assign head_slot   = (total == '0) ? '0 : lol_pkg::SLOT_W'(head);
  assign entry_count = total;

  `AST_IMP(a_count_matches_marks, clk, rst, 1'b1, $countones(mark) == 32'(total))
  `AST_IMP(a_count_bounded, clk, rst, 1'b1, 32'(total) <= lol_pkg::ENTRIES)
  `AST_NEXT(a_start_sets_busy, clk, rst, start && !busy, busy)
  `AST_NEXT(a_unlink_moves_on, clk, rst, state == lol_pkg::S_UNLINK,
    state == lol_pkg::S_APPEND || state == lol_pkg::S_REPORT)
  `AST_NEXT(a_reject_keeps_count, clk, rst, start && !busy && reject_in,
    $stable(total) && $stable(mark))

endmodule
`default_nettype wire

// ===== bench/lru_order_list_top_test.sv =====
// Self-checking LRU order list bench: directed and random requests vs a list predictor.
module lru_order_list_top_test;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int unsigned STALL_LIMIT = 400;

  typedef struct packed {
    logic                       status;
    logic [lol_pkg::SLOT_W-1:0] head_slot;
    logic                       list_empty;
    logic [lol_pkg::CNT_W-1:0]  entry_count;
  } lru_report_t;

  logic                       clk;
  logic                       rst;
  logic                       start;
  logic [1:0]                 opcode;
  logic [lol_pkg::SLOT_W-1:0] slot;
  logic                       busy;
  logic                       done;
  logic                       status;
  logic [lol_pkg::SLOT_W-1:0] head_slot;
  logic                       list_empty;
  logic [lol_pkg::CNT_W-1:0]  entry_count;

  logic [lol_pkg::SLOT_W-1:0] next_of [lol_pkg::ENTRIES];
  logic [lol_pkg::SLOT_W-1:0] prev_of [lol_pkg::ENTRIES];
  bit                         listed [lol_pkg::ENTRIES];
  logic [lol_pkg::SLOT_W-1:0] head_q;
  logic [lol_pkg::SLOT_W-1:0] tail_q;
  int unsigned                listed_n;

  lru_report_t awaited_reports[$];
  lru_report_t oldest_report;
  int unsigned mismatches;
  int unsigned idle_cycles;
  bit          idle_free;

  lru_order_list_top dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .opcode      (opcode),
    .slot        (slot),
    .busy        (busy),
    .done        (done),
    .status      (status),
    .head_slot   (head_slot),
    .list_empty  (list_empty),
    .entry_count (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic void link_at_tail(input logic [lol_pkg::SLOT_W-1:0] s);
    if (listed_n == 0) begin
      head_q = s;
    end else begin
      next_of[tail_q] = s;
      prev_of[s] = tail_q;
    end
    next_of[s] = '0;
    tail_q = s;
  endfunction

  function automatic lru_report_t apply_lru_op(input logic [1:0] op,
                                               input logic [lol_pkg::SLOT_W-1:0] s);
    lru_report_t r;
    logic rejected;
    logic [lol_pkg::SLOT_W-1:0] p;
    logic [lol_pkg::SLOT_W-1:0] n;
    rejected = 1'b0;
    case (op)
      lol_pkg::OP_PUSH: begin
        if (listed[s]) begin
          rejected = 1'b1;
        end else begin
          link_at_tail(s);
          listed[s] = 1'b1;
          listed_n++;
        end
      end
      lol_pkg::OP_POP: begin
        if (listed_n == 0) begin
          rejected = 1'b1;
        end else begin
          listed[head_q] = 1'b0;
          if (listed_n == 1) begin
            head_q = '0;
            tail_q = '0;
          end else begin
            head_q = next_of[head_q];
          end
          listed_n--;
        end
      end
      lol_pkg::OP_TOUCH: begin
        if (listed_n == 0 || !listed[s]) begin
          rejected = 1'b1;
        end else if (s != tail_q) begin
          if (s == head_q) begin
            head_q = next_of[s];
          end else begin
            p = prev_of[s];
            n = next_of[s];
            next_of[p] = n;
            prev_of[n] = p;
          end
          link_at_tail(s);
        end
      end
      default: rejected = 1'b1;
    endcase
    r.status      = rejected;
    r.head_slot   = (listed_n == 0) ? '0 : head_q;
    r.list_empty  = (listed_n == 0);
    r.entry_count = lol_pkg::CNT_W'(listed_n);
    return r;
  endfunction

  function automatic logic [lol_pkg::SLOT_W-1:0] pick_slot(input bit want_listed);
    logic [lol_pkg::SLOT_W-1:0] choices[$];
    for (int k = 0; k < lol_pkg::ENTRIES; k++) begin
      if (listed[k] == want_listed) choices.push_back(lol_pkg::SLOT_W'(k));
    end
    if (choices.size() == 0) begin
      return lol_pkg::SLOT_W'($urandom_range(0, lol_pkg::ENTRIES - 1));
    end
    return choices[$urandom_range(0, choices.size() - 1)];
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  task automatic send_request(input logic [1:0] op, input logic [lol_pkg::SLOT_W-1:0] s);
    int unsigned gap;
    gap = idle_free ? 0 : $urandom_range(0, 17);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start  <= 1'b1;
    opcode <= op;
    slot   <= s;
    @(posedge clk);
    while (busy) @(posedge clk);
    awaited_reports.push_back(apply_lru_op(op, s));
  endtask

  task automatic wait_for_reports();
    start <= 1'b0;
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst && done) begin
      if (awaited_reports.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual status=%0d head=%0d",
                 $time, status, head_slot);
        $display("%0t: unexpected result, actual empty=%0d count=%0d",
                 $time, list_empty, entry_count);
        mismatches++;
      end else begin
        oldest_report = awaited_reports.pop_front();
        check_field("status", oldest_report.status, status);
        check_field("head_slot", oldest_report.head_slot, head_slot);
        check_field("list_empty", oldest_report.list_empty, list_empty);
        check_field("entry_count", oldest_report.entry_count, entry_count);
      end
    end
  end

  initial begin : watchdog
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((start && !busy) || done) idle_cycles = 0;
      else idle_cycles++;
    end
    $display("lru_order_list_top_test: FAIL");
    $finish;
  end

  task automatic test_rejects_on_empty();
    send_request(lol_pkg::OP_POP, '0);
    send_request(lol_pkg::OP_TOUCH, '0);
    send_request(lol_pkg::OP_TOUCH, '1);
    send_request(OP_UNUSED, '1);
    send_request(lol_pkg::OP_PUSH, '0);
    send_request(lol_pkg::OP_POP, '1);
  endtask

  task automatic test_reordering();
    send_request(lol_pkg::OP_PUSH, 4'd0);
    send_request(lol_pkg::OP_PUSH, 4'd15);
    send_request(lol_pkg::OP_PUSH, 4'd7);
    send_request(lol_pkg::OP_PUSH, 4'd15);
    send_request(lol_pkg::OP_TOUCH, 4'd7);
    send_request(lol_pkg::OP_TOUCH, 4'd15);
    send_request(lol_pkg::OP_TOUCH, 4'd0);
    send_request(lol_pkg::OP_TOUCH, 4'd3);
    send_request(lol_pkg::OP_POP, 4'd9);
  endtask

  task automatic test_full_list(input int unsigned passes);
    logic [lol_pkg::SLOT_W-1:0] order [lol_pkg::ENTRIES];
    logic [lol_pkg::SLOT_W-1:0] swap;
    int unsigned j;
    for (int p = 0; p < passes; p++) begin
      while (listed_n != 0) begin
        send_request(lol_pkg::OP_POP,
                     lol_pkg::SLOT_W'($urandom_range(0, lol_pkg::ENTRIES - 1)));
      end
      for (int k = 0; k < lol_pkg::ENTRIES; k++) order[k] = lol_pkg::SLOT_W'(k);
      for (int k = lol_pkg::ENTRIES - 1; k > 0; k--) begin
        j = $urandom_range(0, k);
        swap = order[k];
        order[k] = order[j];
        order[j] = swap;
      end
      idle_free = (p == 0);
      for (int k = 0; k < lol_pkg::ENTRIES; k++) send_request(lol_pkg::OP_PUSH, order[k]);
      send_request(lol_pkg::OP_PUSH,
                   lol_pkg::SLOT_W'($urandom_range(0, lol_pkg::ENTRIES - 1)));
      for (int k = 0; k < lol_pkg::ENTRIES; k++) begin
        send_request(lol_pkg::OP_TOUCH, pick_slot(1'b1));
      end
      for (int k = 0; k <= lol_pkg::ENTRIES; k++) begin
        send_request(lol_pkg::OP_POP,
                     lol_pkg::SLOT_W'($urandom_range(0, lol_pkg::ENTRIES - 1)));
      end
    end
    idle_free = 1'b0;
  endtask

  task automatic test_random_mix(input int unsigned rounds);
    int unsigned bias;
    int unsigned pick;
    logic [1:0] op;
    logic [lol_pkg::SLOT_W-1:0] s;
    for (int r = 0; r < rounds; r++) begin
      bias = $urandom_range(0, 2);
      idle_free = ($urandom_range(0, 3) == 0);
      for (int i = 0; i < 40; i++) begin
        pick = $urandom_range(0, 99);
        if (pick >= 97) op = OP_UNUSED;
        else if (pick < (bias == 0 ? 55 : bias == 1 ? 20 : 35)) op = lol_pkg::OP_PUSH;
        else if (pick < (bias == 0 ? 85 : bias == 1 ? 45 : 65)) op = lol_pkg::OP_TOUCH;
        else op = lol_pkg::OP_POP;
        if (op == lol_pkg::OP_POP || op == OP_UNUSED || $urandom_range(0, 99) < 15) begin
          s = lol_pkg::SLOT_W'($urandom_range(0, lol_pkg::ENTRIES - 1));
        end else begin
          s = pick_slot(op == lol_pkg::OP_TOUCH);
        end
        send_request(op, s);
      end
      if (r % 8 == 7) wait_for_reports();
    end
    idle_free = 1'b0;
  endtask

  initial begin
    rst    <= 1'b1;
    start  <= 1'b0;
    opcode <= lol_pkg::OP_PUSH;
    slot   <= '0;
    mismatches = 0;
    idle_free  = 1'b0;
    for (int k = 0; k < lol_pkg::ENTRIES; k++) begin
      next_of[k] = '0;
      prev_of[k] = '0;
      listed[k]  = 1'b0;
    end
    head_q   = '0;
    tail_q   = '0;
    listed_n = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_rejects_on_empty();
    test_reordering();
    wait_for_reports();
    test_full_list(3);
    test_random_mix(45);

    wait_for_reports();
    repeat (10) @(posedge clk);
    if (mismatches == 0 && awaited_reports.size() == 0) begin
      $display("lru_order_list_top_test: PASS");
    end else begin
      $display("lru_order_list_top_test: FAIL");
    end
    $finish;
  end

endmodule
